// ===== hdl/mrss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix row sum sorter package
// Shared types, codes and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package mrss_pkg;

	localparam int ELEM_W    = 32;
	localparam int SUM_W     = 36;
	localparam int CFG_W     = 5;
	localparam int REG_IDX_W = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	localparam logic [REG_IDX_W-1:0] REG_ROWS = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_COLS = REG_IDX_W'(1);

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_READ = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		KSEL_I,
		KSEL_J,
		KSEL_ROW
	} key_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT_RDI,
		ST_SORT_CAPI,
		ST_SORT_RDJ,
		ST_SORT_CMPJ,
		ST_SORT_WRI,
		ST_RD_KEY,
		ST_RD_ELEM,
		ST_RD_OUT,
		ST_NR_OUT
	} state_t;

	typedef struct packed {
		logic     load;
		logic     key_rd;
		key_sel_t key_sel;
		logic     cap_i;
		logic     cmp_j;
		logic     wr_i;
		logic     next_i;
		logic     sort_done;
		logic     elem_rd;
		logic     out_load;
		logic     out_err;
	} dp_cmd_t;

	typedef struct packed {
		logic load_last;
		logic i_last;
		logic j_last;
		logic sorted_ready;
		logic out_free;
	} dp_status_t;

endpackage

// ===== hdl/mrss_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix row sum sorter datapath
// Element store, key table of row sums and row order, position counters,
// row accumulator, sort registers and the output register.
// ----------------------------------------------------------------------------
module mrss_datapath import mrss_pkg::*; #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic [REG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_W-1:0]            cfg_data,
	input  logic signed [ELEM_W-1:0]    element_value,
	input  dp_cmd_t                     cmd,
	output dp_status_t                  status,
	input  logic                        out_ready,
	output logic                        out_valid,
	output logic signed [ELEM_W-1:0]    sorted_value,
	output logic signed [SUM_W-1:0]     row_sum,
	output logic                        last_element,
	output logic                        not_ready
);

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW   = $clog2(MAX_ROWS + 1);
	localparam int CCW   = $clog2(MAX_COLS + 1);
	localparam int AW    = RW + CW;
	localparam int ACC_W = ELEM_W + CW;
	localparam int EXT_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;

	localparam logic signed [EXT_W-1:0] SAT_HI = EXT_W'(SUM_MAX);
	localparam logic signed [EXT_W-1:0] SAT_LO = EXT_W'(SUM_MIN);

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [RW-1:0]           order;
	} key_t;

	logic [CFG_W-1:0] rows_q, cols_q;
	logic [RCW-1:0]   nr, nr_m1;
	logic [CCW-1:0]   nc, nc_m1;

	logic [RW-1:0] ld_row_q, rd_row_q, i_q, j_q;
	logic [CW-1:0] ld_col_q, rd_col_q;
	logic          sorted_q;
	logic          out_valid_q;

	logic signed [ACC_W-1:0] acc_q, acc_next, elem_ext;
	logic signed [EXT_W-1:0] sum_ext;
	logic signed [SUM_W-1:0] sat_sum;

	key_t          key_mem [MAX_ROWS];
	key_t          key_q, cur_q, key_wd;
	logic          key_we;
	logic [RW-1:0] key_wa, key_ra;

	logic [ELEM_W-1:0] elem_mem [2**AW];
	logic [ELEM_W-1:0] elem_q;

	logic ld_last_col, ld_last_row, rd_last_col, rd_last_row, swap;

	logic signed [ELEM_W-1:0] sorted_value_q;
	logic signed [SUM_W-1:0]  row_sum_q;
	logic                     last_q, not_ready_q;

	always_comb begin
		if (rows_q == '0) begin
			nr = RCW'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			nr = RCW'(MAX_ROWS);
		end else begin
			nr = RCW'(rows_q);
		end
		if (cols_q == '0) begin
			nc = CCW'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			nc = CCW'(MAX_COLS);
		end else begin
			nc = CCW'(cols_q);
		end
		nr_m1 = nr - RCW'(1);
		nc_m1 = nc - CCW'(1);
	end

	assign ld_last_col = (CCW'(ld_col_q) == nc_m1);
	assign ld_last_row = (RCW'(ld_row_q) == nr_m1);
	assign rd_last_col = (CCW'(rd_col_q) == nc_m1);
	assign rd_last_row = (RCW'(rd_row_q) == nr_m1);

	assign elem_ext = ACC_W'(element_value);
	assign acc_next = (ld_col_q == '0) ? elem_ext : acc_q + elem_ext;
	assign sum_ext  = EXT_W'(acc_next);

	always_comb begin
		if (sum_ext > SAT_HI) begin
			sat_sum = SUM_MAX;
		end else if (sum_ext < SAT_LO) begin
			sat_sum = SUM_MIN;
		end else begin
			sat_sum = SUM_W'(sum_ext);
		end
	end

	assign swap = ($signed(cur_q.sum) > $signed(key_q.sum));

	always_comb begin
		key_we = 1'b0;
		key_wa = '0;
		key_wd = '0;
		if (cmd.load && ld_last_col) begin
			key_we       = 1'b1;
			key_wa       = ld_row_q;
			key_wd.sum   = sat_sum;
			key_wd.order = ld_row_q;
		end else if (cmd.cmp_j && swap) begin
			key_we = 1'b1;
			key_wa = j_q;
			key_wd = cur_q;
		end else if (cmd.wr_i) begin
			key_we = 1'b1;
			key_wa = i_q;
			key_wd = cur_q;
		end
	end

	always_comb begin
		case (cmd.key_sel)
			KSEL_I:   key_ra = i_q;
			KSEL_J:   key_ra = j_q;
			KSEL_ROW: key_ra = rd_row_q;
			default:  key_ra = i_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		if (cmd.key_rd) begin
			key_q <= key_mem[key_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			elem_mem[{ld_row_q, ld_col_q}] <= element_value;
		end
		if (cmd.elem_rd) begin
			elem_q <= elem_mem[{key_q.order, rd_col_q}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= acc_next;
		end
		if (cmd.cap_i || (cmd.cmp_j && swap)) begin
			cur_q <= key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= CFG_RESET;
			cols_q   <= CFG_RESET;
			ld_row_q <= '0;
			ld_col_q <= '0;
			rd_row_q <= '0;
			rd_col_q <= '0;
			i_q      <= '0;
			j_q      <= '0;
			sorted_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_ROWS) begin
				rows_q <= cfg_data;
			end
			if (cfg_index == REG_COLS) begin
				cols_q <= cfg_data;
			end
			if ((cfg_index == REG_ROWS) || (cfg_index == REG_COLS)) begin
				ld_row_q <= '0;
				ld_col_q <= '0;
				rd_row_q <= '0;
				rd_col_q <= '0;
				sorted_q <= 1'b0;
			end
		end else begin
			if (cmd.load) begin
				if (sorted_q) begin
					sorted_q <= 1'b0;
					rd_row_q <= '0;
					rd_col_q <= '0;
				end
				if (ld_last_col) begin
					ld_col_q <= '0;
					ld_row_q <= ld_last_row ? '0 : ld_row_q + RW'(1);
				end else begin
					ld_col_q <= ld_col_q + CW'(1);
				end
			end
			if (cmd.cap_i) begin
				j_q <= i_q + RW'(1);
			end
			if (cmd.cmp_j) begin
				j_q <= j_q + RW'(1);
			end
			if (cmd.next_i) begin
				i_q <= i_q + RW'(1);
			end
			if (cmd.sort_done) begin
				sorted_q <= 1'b1;
				i_q      <= '0;
				rd_row_q <= '0;
				rd_col_q <= '0;
			end
			if (cmd.out_load && !cmd.out_err) begin
				if (rd_last_col) begin
					rd_col_q <= '0;
					rd_row_q <= rd_last_row ? '0 : rd_row_q + RW'(1);
				end else begin
					rd_col_q <= rd_col_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_err) begin
				sorted_value_q <= '0;
				row_sum_q      <= '0;
				last_q         <= 1'b0;
				not_ready_q    <= 1'b1;
			end else begin
				sorted_value_q <= elem_q;
				row_sum_q      <= key_q.sum;
				last_q         <= rd_last_col && rd_last_row;
				not_ready_q    <= 1'b0;
			end
		end
	end

	assign status.load_last    = ld_last_col && ld_last_row;
	assign status.i_last       = (RCW'(i_q) == nr_m1);
	assign status.j_last       = (RCW'(j_q) == nr_m1);
	assign status.sorted_ready = sorted_q;
	assign status.out_free     = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_value_q;
	assign row_sum      = row_sum_q;
	assign last_element = last_q;
	assign not_ready    = not_ready_q;

endmodule

// ===== hdl/mrss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix row sum sorter controller
// Sequences loads, the exchange sort over the key table and sorted reads.
// ----------------------------------------------------------------------------
module mrss_ctrl import mrss_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       kind,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (kind_t'(kind) == KIND_LOAD) begin
						if (status.load_last) begin
							state_next = ST_SORT_RDI;
						end
					end else if (status.sorted_ready) begin
						state_next = ST_RD_KEY;
					end else begin
						state_next = ST_NR_OUT;
					end
				end
			end
			ST_SORT_RDI:  state_next = ST_SORT_CAPI;
			ST_SORT_CAPI: state_next = status.i_last ? ST_SORT_WRI : ST_SORT_RDJ;
			ST_SORT_RDJ:  state_next = ST_SORT_CMPJ;
			ST_SORT_CMPJ: state_next = status.j_last ? ST_SORT_WRI : ST_SORT_RDJ;
			ST_SORT_WRI:  state_next = status.i_last ? ST_IDLE : ST_SORT_RDI;
			ST_RD_KEY:    state_next = ST_RD_ELEM;
			ST_RD_ELEM:   state_next = ST_RD_OUT;
			ST_RD_OUT: begin
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			ST_NR_OUT: begin
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid && (kind_t'(kind) == KIND_LOAD);
			end
			ST_SORT_RDI: begin
				cmd.key_rd  = 1'b1;
				cmd.key_sel = KSEL_I;
			end
			ST_SORT_CAPI: cmd.cap_i = 1'b1;
			ST_SORT_RDJ: begin
				cmd.key_rd  = 1'b1;
				cmd.key_sel = KSEL_J;
			end
			ST_SORT_CMPJ: cmd.cmp_j = 1'b1;
			ST_SORT_WRI: begin
				cmd.wr_i      = 1'b1;
				cmd.sort_done = status.i_last;
				cmd.next_i    = !status.i_last;
			end
			ST_RD_KEY: begin
				cmd.key_rd  = 1'b1;
				cmd.key_sel = KSEL_ROW;
			end
			ST_RD_ELEM: cmd.elem_rd = 1'b1;
			ST_RD_OUT:  cmd.out_load = status.out_free;
			ST_NR_OUT: begin
				cmd.out_load = status.out_free;
				cmd.out_err  = status.out_free;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ===== hdl/matrix_row_sum_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix row sum sorter
// Loads a matrix row by row, orders the rows by ascending row sum with an
// exchange sort over a key table, and reads the sorted matrix back.
//
// A load is stored on acceptance; unless it is the final one, the next
// request is taken in the next cycle. The final load starts the sort, which
// holds off requests until it ends. A sorted read holds off requests through
// the key, element and output states, a read before loading completes
// through the output state only; both wait there while the result register
// is full. Reset is asynchronous and clears configuration to 16 by 16,
// positions and flags; the element store and row sums are not cleared.
// ----------------------------------------------------------------------------
module matrix_row_sum_sorter import mrss_pkg::*; #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [REG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     kind,
	input  logic signed [ELEM_W-1:0] element_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [ELEM_W-1:0] sorted_value,
	output logic signed [SUM_W-1:0]  row_sum,
	output logic                     last_element,
	output logic                     not_ready
);

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	mrss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mrss_datapath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.element_value (element_value),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.sorted_value  (sorted_value),
		.row_sum       (row_sum),
		.last_element  (last_element),
		.not_ready     (not_ready)
	);

endmodule

// ===== hdl/mrss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix row sum sorter checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module mrss_checker import mrss_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic                     kind,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [ELEM_W-1:0] sorted_value,
	input logic signed [SUM_W-1:0]  row_sum,
	input logic                     last_element,
	input logic                     not_ready
);

	// A stalled result holds its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sorted_value) &&
		$stable(row_sum) && $stable(last_element) && $stable(not_ready))
		else $error("stalled result changed");

	// An early read reports the error with all other fields cleared.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && not_ready |-> sorted_value == '0 && row_sum == '0 &&
		!last_element)
		else $error("error result carries data");

	// A read request keeps the block busy in the following cycle.
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind_t'(kind) == KIND_READ |=> !in_ready)
		else $error("request taken right after a read");

	// A new result only appears while requests are held off.
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result without a read in progress");

endmodule

bind matrix_row_sum_sorter mrss_checker u_mrss_checker (.*);

// ===== dv/matrix_row_sum_sorter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix row sum sorter checker
// Watches the register, request and result channels of the sorter. It keeps
// its own copy of the matrix, the row sums and the row order, predicts the
// result of every read request and compares each accepted result, field by
// field, with the oldest prediction still due.
// ----------------------------------------------------------------------------
module matrix_row_sum_sorter_checker import mrss_pkg::*; #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready,
	input  logic [REG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic                     kind,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [ELEM_W-1:0] sorted_value,
	input  logic signed [SUM_W-1:0]  row_sum,
	input  logic                     last_element,
	input  logic                     not_ready,
	output int unsigned              mismatches,
	output int unsigned              reads_due
);

	localparam int ROW_IDX_W = $clog2(MAX_ROWS);

	typedef struct packed {
		logic signed [ELEM_W-1:0] value;
		logic signed [SUM_W-1:0]  sum;
		logic                     last;
		logic                     early;
	} read_result_t;

	logic [CFG_W-1:0]         rows_reg;
	logic [CFG_W-1:0]         cols_reg;
	logic signed [ELEM_W-1:0] elems [MAX_ROWS*MAX_COLS];
	logic signed [SUM_W-1:0]  sums [MAX_ROWS];
	logic [ROW_IDX_W-1:0]     order [MAX_ROWS];
	logic [8:0]               load_pos;
	logic [8:0]               read_pos;
	logic                     sorted_flag;
	read_result_t             due_reads [$];

	function automatic int unsigned clamp_count(input logic [CFG_W-1:0] v,
		input int unsigned cap);
		if (v == 0)
			return 1;
		return (v > cap) ? cap : v;
	endfunction

	task automatic reset_copy();
		rows_reg = CFG_RESET;
		cols_reg = CFG_RESET;
		for (int i = 0; i < MAX_ROWS * MAX_COLS; i++)
			elems[i] = '0;
		for (int r = 0; r < MAX_ROWS; r++) begin
			sums[r] = '0;
			order[r] = ROW_IDX_W'(r);
		end
		load_pos = '0;
		read_pos = '0;
		sorted_flag = 1'b0;
		due_reads.delete();
	endtask

	task automatic sort_rows_by_sum(input int unsigned nr, input int unsigned nc);
		logic signed [63:0]      acc;
		logic signed [SUM_W-1:0] tmp_sum;
		logic [ROW_IDX_W-1:0]    tmp_row;
		for (int r = 0; r < nr; r++) begin
			acc = '0;
			for (int c = 0; c < nc; c++)
				acc = acc + elems[r*MAX_COLS + c];
			if (acc > SUM_MAX)
				sums[r] = SUM_MAX;
			else if (acc < SUM_MIN)
				sums[r] = SUM_MIN;
			else
				sums[r] = acc[SUM_W-1:0];
			order[r] = ROW_IDX_W'(r);
		end
		for (int i = 0; i < nr; i++) begin
			for (int j = i + 1; j < nr; j++) begin
				if (sums[i] > sums[j]) begin
					tmp_sum = sums[i];
					tmp_row = order[i];
					sums[i] = sums[j];
					sums[j] = tmp_sum;
					order[i] = order[j];
					order[j] = tmp_row;
				end
			end
		end
	endtask

	task automatic predict_request(input logic k, input logic signed [ELEM_W-1:0] v);
		int unsigned  nr;
		int unsigned  nc;
		int unsigned  total;
		int unsigned  phys;
		read_result_t res;
		nr = clamp_count(rows_reg, MAX_ROWS);
		nc = clamp_count(cols_reg, MAX_COLS);
		total = nr * nc;
		if (k == KIND_LOAD) begin
			if (sorted_flag) begin
				sorted_flag = 1'b0;
				load_pos = '0;
				read_pos = '0;
			end
			if (load_pos >= total)
				load_pos = '0;
			elems[(load_pos / nc) * MAX_COLS + (load_pos % nc)] = v;
			load_pos = load_pos + 1'b1;
			if (load_pos >= total) begin
				sort_rows_by_sum(nr, nc);
				sorted_flag = 1'b1;
				read_pos = '0;
				load_pos = '0;
			end
		end else if (!sorted_flag) begin
			res = '0;
			res.early = 1'b1;
			due_reads.push_back(res);
		end else begin
			if (read_pos >= total)
				read_pos = '0;
			phys = order[read_pos / nc];
			res.value = elems[phys * MAX_COLS + (read_pos % nc)];
			res.sum = sums[read_pos / nc];
			res.last = (read_pos + 1 == total);
			res.early = 1'b0;
			due_reads.push_back(res);
			read_pos = read_pos + 1'b1;
			if (read_pos >= total)
				read_pos = '0;
		end
	endtask

	task automatic compare_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		read_result_t exp_res;
		if (!arst_n) begin
			reset_copy();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROWS || cfg_index == REG_COLS) begin
					if (cfg_index == REG_ROWS)
						rows_reg = cfg_data;
					else
						cols_reg = cfg_data;
					load_pos = '0;
					read_pos = '0;
					sorted_flag = 1'b0;
				end
			end
			if (in_valid && in_ready)
				predict_request(kind, element_value);
			if (out_valid && out_ready) begin
				if (due_reads.size() == 0) begin
					$error("read result arrived with no request outstanding");
					mismatches++;
				end else begin
					exp_res = due_reads.pop_front();
					compare_field("sorted_value", $signed(exp_res.value), $signed(sorted_value));
					compare_field("row_sum", $signed(exp_res.sum), $signed(row_sum));
					compare_field("last_element", exp_res.last, last_element);
					compare_field("not_ready", exp_res.early, not_ready);
				end
			end
		end
		reads_due = due_reads.size();
	end

endmodule

// ===== dv/matrix_row_sum_sorter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix row sum sorter test
// Drives register writes and load and read requests into the sorter while the
// checker beside it predicts and compares every read result. A short directed
// part covers the register extremes, ties, wrap-around and early reads; the
// random part loads and reads matrices of varied sizes with random bursts,
// gaps and result stalls.
// ----------------------------------------------------------------------------
module matrix_row_sum_sorter_test;
	import mrss_pkg::*;

	localparam int MAX_ROWS     = 16;
	localparam int MAX_COLS     = 16;
	localparam int RANDOM_ITEMS = 850;
	localparam int SORT_HOLD    = 3*MAX_ROWS + MAX_ROWS*(MAX_ROWS-1) + 16;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_IDX_W'(2);

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [REG_IDX_W-1:0]     cfg_index = REG_ROWS;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	kind_t                    kind = KIND_LOAD;
	logic signed [ELEM_W-1:0] element_value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [ELEM_W-1:0] sorted_value;
	logic signed [SUM_W-1:0]  row_sum;
	logic                     last_element;
	logic                     not_ready;
	int unsigned              mismatches;
	int unsigned              reads_due;

	int unsigned              cycles = 0;
	int unsigned              burst_left = 0;
	int unsigned              items_sent = 0;
	int unsigned              stall_mode = 0;
	int unsigned              mode_left = 0;
	logic [CFG_W-1:0]         rows_now = CFG_RESET;
	logic [CFG_W-1:0]         cols_now = CFG_RESET;

	matrix_row_sum_sorter #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.element_value(element_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.row_sum      (row_sum),
		.last_element (last_element),
		.not_ready    (not_ready)
	);

	matrix_row_sum_sorter_checker #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.element_value(element_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.row_sum      (row_sum),
		.last_element (last_element),
		.not_ready    (not_ready),
		.mismatches   (mismatches),
		.reads_due    (reads_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			mode_left <= $urandom_range(20, 200);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= ($urandom_range(0, 1) == 1);
			end
			default: begin
				out_ready <= ($urandom_range(0, 7) == 0);
			end
		endcase
	end

	function automatic int unsigned count_of(input logic [CFG_W-1:0] v,
		input int unsigned cap);
		if (v == 0)
			return 1;
		return (v > cap) ? cap : v;
	endfunction

	function automatic logic [CFG_W-1:0] pick_count(input int unsigned cap,
		input logic big_ok);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return big_ok ? CFG_W'(31) : CFG_W'(1);
			2: return big_ok ? CFG_W'($urandom_range(16, 17)) : CFG_W'(cap);
			default: return CFG_W'($urandom_range(1, cap));
		endcase
	endfunction

	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return {1'b0, {(ELEM_W-1){1'b1}}};
			1: return {1'b1, {(ELEM_W-1){1'b0}}};
			2: return $urandom_range(0, 4) - 2;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_req(input kind_t k, input logic [ELEM_W-1:0] v);
		in_valid <= 1'b1;
		kind <= k;
		element_value <= v;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 10);
		end
	endtask

	task automatic wait_idle(input int unsigned hold);
		in_valid <= 1'b0;
		do @(negedge clk); while (reads_due != 0);
		repeat (hold + 1) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_idle(SORT_HOLD);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_ROWS)
			rows_now = val;
		else if (idx == REG_COLS)
			cols_now = val;
	endtask

	initial begin : stimulus
		int unsigned total;
		int unsigned random_start;
		int unsigned n_reads;
		logic        broken;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_req(KIND_READ, '1);

		write_reg(REG_ROWS, CFG_W'(2));
		write_reg(REG_COLS, CFG_W'(2));
		send_req(KIND_LOAD, {1'b0, {(ELEM_W-1){1'b1}}});
		send_req(KIND_LOAD, {1'b0, {(ELEM_W-1){1'b1}}});
		send_req(KIND_LOAD, {1'b1, {(ELEM_W-1){1'b0}}});
		send_req(KIND_LOAD, {1'b1, {(ELEM_W-1){1'b0}}});
		repeat (5) send_req(KIND_READ, $urandom());
		send_req(KIND_LOAD, '0);
		send_req(KIND_READ, $urandom());

		write_reg(REG_ROWS, '0);
		write_reg(REG_COLS, '0);
		send_req(KIND_LOAD, $urandom());
		repeat (2) send_req(KIND_READ, $urandom());
		write_reg(REG_UNUSED, '1);
		send_req(KIND_READ, $urandom());

		write_reg(REG_ROWS, CFG_W'(3));
		write_reg(REG_COLS, CFG_W'(1));
		send_req(KIND_LOAD, ELEM_W'(5));
		send_req(KIND_LOAD, ELEM_W'(5));
		send_req(KIND_LOAD, '1);
		repeat (3) send_req(KIND_READ, $urandom());

		random_start = items_sent;
		write_reg(REG_ROWS, CFG_W'(31));
		write_reg(REG_COLS, CFG_W'(17));
		repeat (count_of(rows_now, MAX_ROWS) * count_of(cols_now, MAX_COLS))
			send_req(KIND_LOAD, rand_elem());
		repeat ($urandom_range(20, 40)) send_req(KIND_READ, $urandom());

		while (items_sent - random_start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 5))
				0: begin
					write_reg(REG_ROWS, pick_count(6, count_of(cols_now, MAX_COLS) <= 4));
				end
				1: begin
					write_reg(REG_COLS, pick_count(4, count_of(rows_now, MAX_ROWS) <= 6));
				end
				2: begin
					write_reg(REG_UNUSED, CFG_W'($urandom()));
				end
				default: begin
					write_reg(REG_ROWS, pick_count(6, 1'b1));
					write_reg(REG_COLS, pick_count(4, count_of(rows_now, MAX_ROWS) <= 6));
				end
			endcase
			total = count_of(rows_now, MAX_ROWS) * count_of(cols_now, MAX_COLS);
			broken = 1'b0;
			repeat ($urandom_range(1, 3)) begin
				if (!broken) begin
					if ($urandom_range(0, 7) == 0) begin
						repeat ($urandom_range(0, total - 1)) send_req(KIND_LOAD, rand_elem());
						repeat ($urandom_range(1, 2)) send_req(KIND_READ, $urandom());
						broken = 1'b1;
					end else begin
						repeat (total) begin
							if ($urandom_range(0, 15) == 0)
								send_req(KIND_READ, $urandom());
							send_req(KIND_LOAD, rand_elem());
						end
						n_reads = total * $urandom_range(1, 2) + $urandom_range(0, 3);
						repeat (n_reads) send_req(KIND_READ, $urandom());
					end
					if ($urandom_range(0, 3) == 0)
						wait_idle(0);
				end
			end
		end

		wait_idle(SORT_HOLD);
		@(negedge clk);
		if (mismatches == 0 && reads_due == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
